### hdl/ucmq_pkg.sv
package ucmq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_HANDLE_BITS = 8;

    localparam int PEER_W   = 16;
    localparam int TAG_W    = 32;
    localparam int HANDLE_W = 8;
    localparam int OCC_W    = 5;

    // request codes
    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_MATCH   = 2'd1;
    localparam logic [1:0] REQ_CLEAR   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_NONEMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [PEER_W-1:0]   peer_id;
        logic [TAG_W-1:0]    msg_tag;
        logic [HANDLE_W-1:0] handle_in;
    } t_req;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] handle_out;
        logic [1:0]          status;
        logic [OCC_W-1:0]    occupancy;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

endpackage

### hdl/ucmq_mem.sv
module ucmq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 56
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/ucmq_ctrl.sv
module ucmq_ctrl #(
    parameter int QUEUE_DEPTH = ucmq_pkg::DEF_QUEUE_DEPTH,
    parameter int HANDLE_BITS = ucmq_pkg::DEF_HANDLE_BITS,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int HW = (HANDLE_BITS < ucmq_pkg::HANDLE_W) ? HANDLE_BITS : ucmq_pkg::HANDLE_W,
    localparam int EW = ucmq_pkg::PEER_W + ucmq_pkg::TAG_W + HW
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ucmq_pkg::t_req i_req,
    output logic           o_busy,
    output logic           o_done,
    output ucmq_pkg::t_rsp o_rsp,
    output logic           o_wr_en,
    output logic [AW-1:0]  o_wr_addr,
    output logic [EW-1:0]  o_wr_data,
    output logic           o_rd_en,
    output logic [AW-1:0]  o_rd_addr,
    input  logic [EW-1:0]  i_rd_data
);

    import ucmq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_cmp, n_cmp;
    logic [PEER_W-1:0] r_peer, n_peer;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [HW-1:0]     r_handle, n_handle;
    logic              r_found, n_found;
    logic              r_done, n_done;
    t_rsp              r_rsp, n_rsp;

    logic [PEER_W-1:0] rd_peer;
    logic [TAG_W-1:0]  rd_tag;
    logic [HW-1:0]     rd_handle;
    logic [CW-1:0]     cmp_next;
    logic              more;
    logic              hit;

    assign rd_peer   = i_rd_data[EW-1 -: PEER_W];
    assign rd_tag    = i_rd_data[HW +: TAG_W];
    assign rd_handle = i_rd_data[HW-1:0];
    assign cmp_next  = CW'(r_cmp) + CW'(1);
    assign more      = cmp_next < r_count;
    assign hit       = (rd_peer == r_peer) && (rd_tag == r_tag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp    <= n_cmp;
        r_peer   <= n_peer;
        r_tag    <= n_tag;
        r_handle <= n_handle;
        r_rsp    <= n_rsp;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cmp     = r_cmp;
        n_peer    = r_peer;
        n_tag     = r_tag;
        n_handle  = r_handle;
        n_found   = r_found;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        o_wr_en   = 1'b0;
        o_wr_addr = r_count[AW-1:0];
        o_wr_data = {i_req.peer_id, i_req.msg_tag, i_req.handle_in[HW-1:0]};
        o_rd_en   = 1'b0;
        o_rd_addr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_rsp.found      = 1'b0;
                    n_rsp.handle_out = '0;
                    n_rsp.status     = ST_OK;
                    unique case (i_req.req_type)
                        REQ_ENQUEUE: begin
                            n_done = 1'b1;
                            if (r_count < CW'(QUEUE_DEPTH)) begin
                                o_wr_en = 1'b1;
                                n_count = r_count + CW'(1);
                            end else begin
                                n_rsp.status = ST_DROPPED;
                            end
                        end
                        REQ_MATCH: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                // first read goes out now, data lands in the scan state
                                o_rd_en = 1'b1;
                                n_cmp   = '0;
                                n_peer  = i_req.peer_id;
                                n_tag   = i_req.msg_tag;
                                n_found = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        REQ_CLEAR: begin
                            n_done  = 1'b1;
                            n_count = '0;
                            if (r_count != '0) begin
                                n_rsp.status = ST_NONEMPTY;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                    n_rsp.occupancy = OCC_W'(n_count);
                end
            end
            S_SCAN: begin
                // read of the next slot overlaps the compare of this one
                o_rd_en   = more;
                o_rd_addr = cmp_next[AW-1:0];
                n_cmp     = cmp_next[AW-1:0];
                if (hit) begin
                    n_found  = 1'b1;
                    n_handle = rd_handle;
                    if (more) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_count          = r_count - CW'(1);
                        n_done           = 1'b1;
                        n_rsp.found      = 1'b1;
                        n_rsp.handle_out = HANDLE_W'(rd_handle);
                        n_rsp.status     = ST_OK;
                        n_rsp.occupancy  = OCC_W'(n_count);
                        n_state          = S_IDLE;
                    end
                end else if (!more) begin
                    n_done           = 1'b1;
                    n_rsp.found      = 1'b0;
                    n_rsp.handle_out = '0;
                    n_rsp.status     = ST_OK;
                    n_rsp.occupancy  = OCC_W'(r_count);
                    n_state          = S_IDLE;
                end
            end
            S_SHIFT: begin
                // move each later slot down by one to close the gap
                o_wr_en   = 1'b1;
                o_wr_addr = r_cmp - AW'(1);
                o_wr_data = i_rd_data;
                o_rd_en   = more;
                o_rd_addr = cmp_next[AW-1:0];
                n_cmp     = cmp_next[AW-1:0];
                if (!more) begin
                    n_count          = r_count - CW'(1);
                    n_done           = 1'b1;
                    n_rsp.found      = 1'b1;
                    n_rsp.handle_out = HANDLE_W'(r_handle);
                    n_rsp.status     = ST_OK;
                    n_rsp.occupancy  = OCC_W'(n_count);
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("result strobe while a match is still running");

    a_shift_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHIFT |-> r_found)
        else $error("compaction without a matched entry");

    a_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && o_rd_en) |-> o_wr_addr != o_rd_addr)
        else $error("read and write of the same slot in one cycle");

    a_pop_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_rsp.found) |-> r_count == $past(r_count) - CW'(1))
        else $error("match did not remove exactly one entry");

endmodule

### hdl/unexpected_connection_match_queue_unit.sv
// queue of unexpected connections kept oldest first in one single-port-read
// memory. an item is taken when start is high and busy is low; its result
// shows on o_rsp for exactly one cycle with o_done high and cannot be held
// off. enqueue, clear and unused codes keep busy low and give their result
// in the cycle after the item. a match on a queue of n entries reads the
// slots one a cycle through the memory read port, comparing each as it
// arrives and, after a hit, writing each later slot back one place lower,
// so busy stays high until the last slot is done; the result follows in the
// next cycle, as for an empty queue. reset needs no clearing pass.
module unexpected_connection_match_queue_unit #(
    parameter int QUEUE_DEPTH = ucmq_pkg::DEF_QUEUE_DEPTH,
    parameter int HANDLE_BITS = ucmq_pkg::DEF_HANDLE_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  ucmq_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output ucmq_pkg::t_rsp o_rsp
);

    import ucmq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int EW = PEER_W + TAG_W + HW;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    ucmq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_req),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_rsp     (o_rsp),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    ucmq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .DW    (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
